/* rtl/core/crcs_pkg.sv */
package crcs_pkg;

   localparam int COORD_W     = 8;
   localparam int COORD_RANGE = 256;
   localparam int CURV_W      = 16;
   localparam int MAX_W       = 15;
   localparam int WIDTH_W     = 9;
   localparam int SCORE_W     = 32;
   localparam int PROD_W      = MAX_W + WIDTH_W;
   localparam int WIDTH_LIMIT = 511;
   localparam int QUEUE_DEPTH = 4;
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_READ   = 1'b1
   } action_type;

   typedef enum logic {
      KIND_CENTER = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   // one store operation, and later one result
   typedef struct packed {
      kind_type             kind;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [SCORE_W-1:0]   score;
   } item_type;

endpackage

/* rtl/core/crcs_queue.sv */
module crcs_queue #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic [$clog2(DEPTH+1)-1:0]   level,
   output logic                         full,
   output logic                         empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             do_push, do_pop;

   assign full     = (level_ff == LW'(DEPTH));
   assign empty    = (level_ff == '0);
   assign level    = level_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/crcs_front.sv */
module crcs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  crcs_pkg::action_type              action,
   input  logic [crcs_pkg::COORD_W-1:0]      row,
   input  logic [crcs_pkg::COORD_W-1:0]      col,
   input  logic signed [crcs_pkg::CURV_W-1:0] curvature,
   input  logic                              profile_end,
   output logic                              op_valid,
   output crcs_pkg::item_type                op
);

   import crcs_pkg::*;

   logic [WIDTH_W-1:0] run_width_ff, run_width_in;
   logic [MAX_W-1:0]   run_max_ff, run_max_in;
   logic [COORD_W-1:0] run_row_ff, run_row_in;
   logic [COORD_W-1:0] run_col_ff, run_col_in;

   logic               positive;
   logic               take_max;
   logic [WIDTH_W-1:0] grown_width;
   logic [MAX_W-1:0]   grown_max;
   logic [COORD_W-1:0] grown_row, grown_col;
   logic [WIDTH_W-1:0] end_width;
   logic [MAX_W-1:0]   end_max;
   logic [PROD_W-1:0]  product;

   assign positive    = (curvature > 0);
   assign take_max    = (run_width_ff == '0) || (curvature[MAX_W-1:0] > run_max_ff);
   assign grown_max   = take_max ? curvature[MAX_W-1:0] : run_max_ff;
   assign grown_row   = take_max ? row : run_row_ff;
   assign grown_col   = take_max ? col : run_col_ff;
   assign grown_width = (run_width_ff < WIDTH_W'(WIDTH_LIMIT)) ? run_width_ff + 1'b1
                                                                : run_width_ff;

   // a positive sample at profile end joins the run before scoring
   assign end_max   = positive ? grown_max : run_max_ff;
   assign end_width = positive ? grown_width : run_width_ff;
   assign product   = PROD_W'(end_max) * PROD_W'(end_width);

   always_comb begin
      run_width_in = run_width_ff;
      run_max_in   = run_max_ff;
      run_row_in   = run_row_ff;
      run_col_in   = run_col_ff;
      op_valid     = 1'b0;
      op.kind      = KIND_READ;
      op.row       = row;
      op.col       = col;
      op.score     = SCORE_W'(product);
      if (accept) begin
         if (action == ACT_READ) begin
            op_valid = 1'b1;
         end else if (positive && !profile_end) begin
            run_width_in = grown_width;
            run_max_in   = grown_max;
            run_row_in   = grown_row;
            run_col_in   = grown_col;
         end else if (positive || (run_width_ff != '0)) begin
            op_valid     = 1'b1;
            op.kind      = KIND_CENTER;
            op.row       = positive ? grown_row : run_row_ff;
            op.col       = positive ? grown_col : run_col_ff;
            run_width_in = '0;
            run_max_in   = '0;
            run_row_in   = '0;
            run_col_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_width_ff <= '0;
         run_max_ff   <= '0;
         run_row_ff   <= '0;
         run_col_ff   <= '0;
      end else begin
         run_width_ff <= run_width_in;
         run_max_ff   <= run_max_in;
         run_row_ff   <= run_row_in;
         run_col_ff   <= run_col_in;
      end
   end

endmodule

/* rtl/core/crcs_back.sv */
module crcs_back #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              op_empty,
   input  crcs_pkg::item_type                op,
   input  logic [crcs_pkg::LEVEL_W-1:0]      out_level,
   output logic                              op_pop,
   output logic                              out_push,
   output crcs_pkg::item_type                out_item,
   output logic                              clearing
);

   import crcs_pkg::*;

   localparam int ENTRIES = MAX_ROWS * MAX_COLS;
   localparam int AW      = $clog2(ENTRIES);
   localparam int RA_W    = $clog2(MAX_ROWS);
   localparam int CA_W    = $clog2(MAX_COLS);

   typedef logic [RA_W-1:0] row_tab_type [COORD_RANGE];
   typedef logic [CA_W-1:0] col_tab_type [COORD_RANGE];

   function automatic row_tab_type row_table();
      row_tab_type t;
      for (int i = 0; i < COORD_RANGE; i++) begin
         t[i] = RA_W'(i % MAX_ROWS);
      end
      return t;
   endfunction

   function automatic col_tab_type col_table();
      col_tab_type t;
      for (int i = 0; i < COORD_RANGE; i++) begin
         t[i] = CA_W'(i % MAX_COLS);
      end
      return t;
   endfunction

   localparam row_tab_type ROW_WRAP = row_table();
   localparam col_tab_type COL_WRAP = col_table();

   logic [SCORE_W-1:0] store [ENTRIES];

   logic               clear_ff, clear_in;
   logic [AW-1:0]      clear_addr_ff, clear_addr_in;
   logic               s2_valid_ff;
   item_type           s2_item_ff;
   logic [AW-1:0]      s2_addr_ff;
   logic [SCORE_W-1:0] rd_data_ff;
   logic               wr_valid_ff;
   logic [AW-1:0]      wr_addr_ff;
   logic [SCORE_W-1:0] wr_data_ff;

   logic [AW-1:0]      issue_addr;
   logic               room;
   logic [SCORE_W-1:0] old_value;
   logic [SCORE_W:0]   sum;
   logic [SCORE_W-1:0] new_value;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [SCORE_W-1:0] mem_wdata;

   assign issue_addr = AW'(AW'(ROW_WRAP[op.row]) * AW'(MAX_COLS)) + AW'(COL_WRAP[op.col]);

   // keep a slot in the result queue for the item already in the update stage
   assign room   = ((LEVEL_W + 1)'(out_level) + (LEVEL_W + 1)'(s2_valid_ff))
                   < (LEVEL_W + 1)'(QUEUE_DEPTH);
   assign op_pop   = !clear_ff && !op_empty && room;
   assign clearing = clear_ff;

   // the entry written last cycle is newer than what the store returned
   assign old_value = (wr_valid_ff && (wr_addr_ff == s2_addr_ff)) ? wr_data_ff : rd_data_ff;
   assign sum       = {1'b0, old_value} + {1'b0, s2_item_ff.score};

   always_comb begin
      out_item = s2_item_ff;
      if (s2_item_ff.kind == KIND_READ) begin
         new_value      = '0;
         out_item.score = old_value;
      end else begin
         new_value = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
      end
   end

   assign out_push  = s2_valid_ff;
   assign mem_we    = clear_ff || s2_valid_ff;
   assign mem_waddr = clear_ff ? clear_addr_ff : s2_addr_ff;
   assign mem_wdata = clear_ff ? '0 : new_value;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == AW'(ENTRIES - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s2_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s2_valid_ff   <= op_pop;
         wr_valid_ff   <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_item_ff <= op;
      s2_addr_ff <= issue_addr;
      wr_addr_ff <= s2_addr_ff;
      wr_data_ff <= new_value;
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         rd_data_ff <= store[issue_addr];
      end
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
   end

endmodule

/* rtl/core/curvature_region_center_scorer_top.sv */
// curvature region center scorer
// input queue side: present a transaction on the req_ ports with push high;
// it is taken at a clock edge where full is low. a transaction is either a
// curvature sample of a profile or a read-and-clear of one pixel's score.
// result queue side: while empty is low the oldest result sits on the rsp_
// ports; pop high at a clock edge takes it.
// a sample that closes a positive-curvature run yields a center transaction
// (max times width at the max position); a read yields the pixel's score.
// throughput: one transaction per cycle outside the clearing pass and while pop
// stays high, set by the single read port of the score store with a one-entry
// write-back forward in the update stage. path: a result passes the op queue,
// the update stage register and the result queue. reset: run state clears at
// once; then a clearing pass zeroes every store entry, one entry a cycle, with full held high.
// stall: when pop stays low the result queue fills, the store stage holds,
// the op queue fills and full rises; nothing is dropped.
module curvature_region_center_scorer_top #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_action,
   input  logic [crcs_pkg::COORD_W-1:0]       req_row,
   input  logic [crcs_pkg::COORD_W-1:0]       req_col,
   input  logic signed [crcs_pkg::CURV_W-1:0] req_curvature,
   input  logic                               req_profile_end,
   output logic                               empty,
   input  logic                               pop,
   output logic                               rsp_kind,
   output logic [crcs_pkg::COORD_W-1:0]       rsp_center_row,
   output logic [crcs_pkg::COORD_W-1:0]       rsp_center_col,
   output logic [crcs_pkg::SCORE_W-1:0]       rsp_score
);

   import crcs_pkg::*;

   localparam int ITEM_W = $bits(item_type);

   logic               accept;
   action_type         action;
   logic               op_valid;
   item_type           op_new;
   // op queue between front and back
   logic [ITEM_W-1:0]  op_head_bits;
   item_type           op_head;
   logic               op_pop, op_full, op_empty;
   logic [LEVEL_W-1:0] op_level;
   // result queue
   logic               out_push;
   item_type           out_item;
   logic [ITEM_W-1:0]  out_head_bits;
   item_type           out_head;
   logic               out_full;
   logic [LEVEL_W-1:0] out_level;
   logic               clearing;

   assign full   = clearing || op_full;
   assign accept = push && !full;
   assign action = action_type'(req_action);

   // run tracking and op build
   crcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (action),
      .row         (req_row),
      .col         (req_col),
      .curvature   (req_curvature),
      .profile_end (req_profile_end),
      .op_valid    (op_valid),
      .op          (op_new)
   );

   crcs_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_valid),
      .push_data (op_new),
      .pop       (op_pop),
      .pop_data  (op_head_bits),
      .level     (op_level),
      .full      (op_full),
      .empty     (op_empty)
   );

   assign op_head = item_type'(op_head_bits);

   // score store read-modify-write
   crcs_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (op_empty),
      .op        (op_head),
      .out_level (out_level),
      .op_pop    (op_pop),
      .out_push  (out_push),
      .out_item  (out_item),
      .clearing  (clearing)
   );

   crcs_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .pop       (pop),
      .pop_data  (out_head_bits),
      .level     (out_level),
      .full      (out_full),
      .empty     (empty)
   );

   assign out_head       = item_type'(out_head_bits);
   assign rsp_kind       = out_head.kind;
   assign rsp_center_row = out_head.row;
   assign rsp_center_col = out_head.col;
   assign rsp_score      = out_head.score;

   // the back stage reserves room, so a result never meets a full queue
   a_no_result_overflow : assert property (@(posedge clock) disable iff (reset)
      !(out_push && out_full))
      else $error("result queue overflow");

   // the clearing pass starts right after reset
   a_clear_after_reset : assert property (@(posedge clock)
      reset |=> full)
      else $error("input not held off after reset");

   // every accepted read produces a store op
   a_read_makes_op : assert property (@(posedge clock) disable iff (reset)
      (accept && (action == ACT_READ)) |-> op_valid)
      else $error("read transaction lost");

   // op queue level never exceeds its depth
   a_op_level : assert property (@(posedge clock) disable iff (reset)
      op_valid |-> (op_level < LEVEL_W'(QUEUE_DEPTH)))
      else $error("op pushed into full queue");

endmodule

/* tb/sv/curvature_region_center_scorer_top_tb.sv */
`timescale 1ns / 1ps

module curvature_region_center_scorer_top_tb;

   import crcs_pkg::*;

   localparam int IMG_ROWS    = 256;
   localparam int IMG_COLS    = 256;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int RANDOM_TXNS = 900;
   localparam int QUIET_TAIL  = 200;
   // pixel that takes the maximum of a run longer than the width limit
   localparam logic [COORD_W-1:0] SAT_ROW = 8'd200;
   localparam logic [COORD_W-1:0] SAT_COL = 8'd100;
   localparam int LONG_RUN    = 600;

   // tracks positive-curvature runs and the per-pixel center scores, and
   // holds the results the block owes us, oldest first
   class center_score_tracker;
      logic [SCORE_W-1:0]        score_mem [IMG_ROWS*IMG_COLS];
      logic [WIDTH_W-1:0]        run_len;
      logic signed [CURV_W-1:0]  peak;
      logic [COORD_W-1:0]        peak_row;
      logic [COORD_W-1:0]        peak_col;
      item_type                  awaited [$];
      int                        mismatches;

      function new();
         foreach (score_mem[i]) score_mem[i] = '0;
         run_len    = '0;
         peak       = '0;
         peak_row   = '0;
         peak_col   = '0;
         mismatches = 0;
      endfunction

      // one accepted input transaction
      function void absorb(action_type act, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                           logic signed [CURV_W-1:0] curv, logic last);
         int                 idx;
         logic               closes;
         logic [SCORE_W-1:0] prod;
         logic [SCORE_W:0]   sum;
         item_type           it;
         if (act == ACT_READ) begin
            idx = (r % IMG_ROWS) * IMG_COLS + (c % IMG_COLS);
            it = '{kind: KIND_READ, row: r, col: c, score: score_mem[idx]};
            score_mem[idx] = '0;
            awaited.push_back(it);
            return;
         end
         closes = 1'b0;
         if (curv > 0) begin
            // strict compare: the first of equal maxima keeps its position
            if (run_len == 0 || curv > peak) begin
               peak     = curv;
               peak_row = r;
               peak_col = c;
            end
            if (run_len < WIDTH_LIMIT) run_len++;
            closes = last;
         end else if (run_len != 0) begin
            closes = 1'b1;
         end
         if (!closes) return;
         prod = peak[CURV_W-2:0] * run_len;
         idx  = (peak_row % IMG_ROWS) * IMG_COLS + (peak_col % IMG_COLS);
         sum  = {1'b0, score_mem[idx]} + {1'b0, prod};
         score_mem[idx] = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
         it = '{kind: KIND_CENTER, row: peak_row, col: peak_col, score: prod};
         awaited.push_back(it);
         run_len  = '0;
         peak     = '0;
         peak_row = '0;
         peak_col = '0;
      endfunction

      // one accepted result transaction against the oldest expectation
      function void compare(logic k, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                            logic [SCORE_W-1:0] s);
         item_type want;
         if (awaited.size() == 0) begin
            $error("result with nothing awaited: kind %0d row %0d col %0d score %0d",
                   k, r, c, s);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (k !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, k);
            mismatches++;
         end
         if (r !== want.row) begin
            $error("center_row: expected %0d, actual %0d", want.row, r);
            mismatches++;
         end
         if (c !== want.col) begin
            $error("center_col: expected %0d, actual %0d", want.col, c);
            mismatches++;
         end
         if (s !== want.score) begin
            $error("score: expected %0d, actual %0d", want.score, s);
            mismatches++;
         end
      endfunction
   endclass

   // dut signals, all inputs known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push  = 1'b0;
   logic                      full;
   logic                      req_action      = 1'b0;
   logic [COORD_W-1:0]        req_row         = '0;
   logic [COORD_W-1:0]        req_col         = '0;
   logic signed [CURV_W-1:0]  req_curvature   = '0;
   logic                      req_profile_end = 1'b0;
   logic                      empty;
   logic                      pop   = 1'b0;
   logic                      rsp_kind;
   logic [COORD_W-1:0]        rsp_center_row;
   logic [COORD_W-1:0]        rsp_center_col;
   logic [SCORE_W-1:0]        rsp_score;

   center_score_tracker tracker = new();

   // idling switches for the two sides
   bit  send_gaps_on = 1'b1;
   bit  pop_stalls_on = 1'b1;
   int  txn_count = 0;
   int  cycle_count = 0;
   // pixels that recently saw positive curvature, read targets likely nonzero
   logic [2*COORD_W-1:0] hot_pixels [$];

   curvature_region_center_scorer_top #(
      .MAX_COLS (IMG_COLS),
      .MAX_ROWS (IMG_ROWS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_action      (req_action),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_curvature   (req_curvature),
      .req_profile_end (req_profile_end),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_center_row  (rsp_center_row),
      .rsp_center_col  (rsp_center_col),
      .rsp_score       (rsp_score)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop, covers the clearing pass and the long run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: values seen here are the ones before this edge's updates
   always @(posedge clock) begin
      if (!reset && pop && empty === 1'b0)
         tracker.compare(rsp_kind, rsp_center_row, rsp_center_col, rsp_score);
   end

   // pop driver: random stall bursts, otherwise always taking
   always begin
      @(posedge clock);
      if (pop_stalls_on && $urandom_range(0, 9) == 0) begin
         pop <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      pop <= 1'b1;
   end

   // present one transaction and hold it until taken; push stays high after
   task automatic send_txn(action_type act, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                           logic signed [CURV_W-1:0] curv, logic last);
      push            <= 1'b1;
      req_action      <= act;
      req_row         <= r;
      req_col         <= c;
      req_curvature   <= curv;
      req_profile_end <= last;
      do @(posedge clock); while (full !== 1'b0);
      tracker.absorb(act, r, c, curv, last);
      txn_count++;
      if (act == ACT_SAMPLE && curv > 0) begin
         hot_pixels.push_back({r, c});
         if (hot_pixels.size() > 64) void'(hot_pixels.pop_front());
      end
   endtask

   task automatic hold_off(int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (send_gaps_on && $urandom_range(0, 9) == 0) hold_off($urandom_range(1, 12));
   endtask

   // sender waits until every awaited result is back, plus the pipeline depth
   // so a sample with no result cannot still be in flight
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (tracker.awaited.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [CURV_W-1:0] pick_curv(bit positive);
      int mode;
      mode = $urandom_range(0, 5);
      if (positive) begin
         case (mode)
            0:       return 16'sd1;
            1:       return 16'sd32767;
            2, 3:    return CURV_W'($urandom_range(1, 255));
            default: return CURV_W'($urandom_range(1, 32767));
         endcase
      end
      case (mode)
         0:       return 16'sd0;
         1:       return 16'sh8000;
         default: return {1'b1, 15'($urandom)};
      endcase
   endfunction

   initial begin
      logic [COORD_W-1:0]       r;
      logic [COORD_W-1:0]       c;
      logic [2*COORD_W-1:0]     rc;
      logic signed [CURV_W-1:0] cv;
      int                       len;
      int                       dir;
      int                       pick;
      int                       base;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: send_txn waits out the clearing pass on full
      // non-positive samples with no run open, one carrying profile end
      send_txn(ACT_SAMPLE, 8'd0, 8'd0, 16'sh8000, 1'b0);
      send_txn(ACT_SAMPLE, 8'd0, 8'd0, 16'sd0, 1'b1);
      // run closed by a zero sample; equal maxima keep the first position
      send_txn(ACT_SAMPLE, 8'd3, 8'd4, 16'sd100, 1'b0);
      send_txn(ACT_SAMPLE, 8'd3, 8'd5, 16'sd300, 1'b0);
      send_txn(ACT_SAMPLE, 8'd3, 8'd6, 16'sd300, 1'b0);
      send_txn(ACT_SAMPLE, 8'd3, 8'd7, 16'sd0, 1'b0);
      // positive sample with profile end joins the run, then scores it
      send_txn(ACT_SAMPLE, 8'd10, 8'd20, 16'sd32767, 1'b0);
      send_txn(ACT_SAMPLE, 8'd255, 8'd255, 16'sd32767, 1'b1);
      // negative sample with profile end closes the run, scored once
      send_txn(ACT_SAMPLE, 8'd5, 8'd5, 16'sd1, 1'b0);
      send_txn(ACT_SAMPLE, 8'd5, 8'd6, -16'sd1, 1'b1);
      // reads ignore curvature and profile end and clear the entry
      send_txn(ACT_READ, 8'd3, 8'd5, -16'sd1, 1'b1);
      send_txn(ACT_READ, 8'd3, 8'd5, 16'sd0, 1'b0);
      // a read in the middle of a run leaves the run alone
      send_txn(ACT_SAMPLE, 8'd7, 8'd7, 16'sd50, 1'b0);
      send_txn(ACT_READ, 8'd10, 8'd20, 16'sd32767, 1'b0);
      send_txn(ACT_SAMPLE, 8'd7, 8'd8, 16'sd60, 1'b1);
      send_txn(ACT_READ, 8'd7, 8'd8, 16'sh8000, 1'b1);
      // coordinate extremes, never-written pixel
      send_txn(ACT_SAMPLE, 8'd0, 8'd255, 16'sd1, 1'b1);
      send_txn(ACT_SAMPLE, 8'd255, 8'd0, 16'sd32767, 1'b1);
      send_txn(ACT_READ, 8'd0, 8'd255, 16'sd0, 1'b0);
      send_txn(ACT_READ, 8'd255, 8'd0, 16'sd0, 1'b0);
      send_txn(ACT_READ, 8'd0, 8'd0, 16'sd0, 1'b0);

      // sender holds until all results are back
      drain();

      // width limit: one run of the largest curvature overruns 511 samples,
      // closed by a zero sample
      send_gaps_on  = 1'b0;
      pop_stalls_on = 1'b0;
      send_txn(ACT_SAMPLE, SAT_ROW, SAT_COL, 16'sd32767, 1'b0);
      for (int k = 1; k < LONG_RUN; k++)
         send_txn(ACT_SAMPLE, 8'($urandom), 8'($urandom),
                  CURV_W'($urandom_range(1, 32767)), 1'b0);
      send_txn(ACT_SAMPLE, 8'd1, 8'd1, 16'sd0, 1'b0);
      // one more score into the same entry, then read it out twice
      send_txn(ACT_SAMPLE, SAT_ROW, SAT_COL, 16'sd9, 1'b1);
      send_txn(ACT_READ, SAT_ROW, SAT_COL, 16'sd0, 1'b0);
      send_txn(ACT_READ, SAT_ROW, SAT_COL, 16'sd0, 1'b0);
      drain();

      // random: mostly whole profiles, some reads, some noise
      send_gaps_on  = 1'b1;
      pop_stalls_on = 1'b1;
      base = txn_count;
      while (txn_count < base + RANDOM_TXNS) begin
         if (txn_count >= base + RANDOM_TXNS - QUIET_TAIL) begin
            send_gaps_on  = 1'b0;
            pop_stalls_on = 1'b0;
         end
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            // a profile along a row, column, diagonal or anti-diagonal
            len = $urandom_range(1, 16);
            dir = $urandom_range(0, 3);
            r   = 8'($urandom);
            c   = 8'($urandom);
            // a small window makes centers pile up on the same pixels
            if ($urandom_range(0, 3) == 0) begin
               r = r & 8'h0f;
               c = c & 8'h0f;
            end
            for (int k = 0; k < len; k++) begin
               cv = pick_curv($urandom_range(0, 9) < 7);
               send_txn(ACT_SAMPLE, r, c, cv, (k == len - 1) ? 1'b1 : 1'b0);
               maybe_gap();
               case (dir)
                  0: c = c + 8'd1;
                  1: r = r + 8'd1;
                  2: begin r = r + 8'd1; c = c + 8'd1; end
                  default: begin r = r + 8'd1; c = c - 8'd1; end
               endcase
            end
         end else if (pick == 8) begin
            if (hot_pixels.size() != 0 && $urandom_range(0, 4) < 3)
               rc = hot_pixels[$urandom_range(0, hot_pixels.size() - 1)];
            else
               rc = 16'($urandom);
            send_txn(ACT_READ, rc[2*COORD_W-1:COORD_W], rc[COORD_W-1:0],
                     CURV_W'($urandom), 1'($urandom));
            maybe_gap();
         end else begin
            // noise: any field pattern at all
            send_txn(action_type'(1'($urandom)), 8'($urandom), 8'($urandom),
                     CURV_W'($urandom), 1'($urandom));
            maybe_gap();
         end
      end

      drain();
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* curvature_region_center_scorer_top.f */
rtl/core/crcs_pkg.sv
rtl/core/crcs_queue.sv
rtl/core/crcs_front.sv
rtl/core/crcs_back.sv
rtl/core/curvature_region_center_scorer_top.sv
tb/sv/curvature_region_center_scorer_top_tb.sv
